>>> design/prad_pkg.sv
// Shared types, codes and the fixed region table of the region address decoder.
`timescale 1ns / 1ps
`default_nettype none

package prad_pkg;

    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned OFFSET_W    = 21;
    localparam int unsigned SETUP_W     = 10;
    localparam int unsigned REGION_CNT  = 8;
    localparam int unsigned REGION_W    = 3;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned PROBE_COUNT = 9;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ROM  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RAM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TILE = 3'd4;

    localparam logic [1:0] SIZE_64K  = 2'd0;
    localparam logic [1:0] SIZE_128K = 2'd1;
    localparam logic [1:0] SIZE_512K = 2'd2;
    localparam logic [1:0] SIZE_2M   = 2'd3;

    // One window test: a region may own more than one probe.
    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] length_m1;
        logic [ADDR_W-1:0]   mirror;
        logic [ADDR_W-1:0]   start_off;
        logic [ADDR_W-1:0]   backing_base;
    } probe_t;

    typedef struct packed {
        logic                hit;
        logic [OFFSET_W-1:0] offset;
    } probe_res_t;

    // Probes in priority order; region 5 tests its 4K sub-window first.
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{3'd0, KIND_ROM,  21'h03ffff, 24'hfc0000, 24'h000000, 24'h000000},
        '{3'd1, KIND_ROM,  21'h03ffff, 24'hfc0000, 24'h000000, 24'h040000},
        '{3'd2, KIND_TILE, 21'h00ffff, 24'hff0000, 24'h000000, 24'h000000},
        '{3'd3, KIND_RAM,  21'h003fff, 24'hffc000, 24'h000000, 24'hffc000},
        '{3'd4, KIND_RAM,  21'h0007ff, 24'hfff800, 24'h000000, 24'h440000},
        '{3'd5, KIND_RAM,  21'h000fff, 24'hfef000, 24'h010000, 24'h410000},
        '{3'd5, KIND_RAM,  21'h00ffff, 24'hfe0000, 24'h000000, 24'h400000},
        '{3'd6, KIND_RAM,  21'h000fff, 24'hfff000, 24'h000000, 24'h840000},
        '{3'd7, KIND_IO,   21'h003fff, 24'hffc000, 24'h000000, 24'h000000}
    };

    function automatic logic [OFFSET_W-1:0] sel_window_mask(input logic [1:0] sel);
        logic [OFFSET_W-1:0] m;
        case (sel)
            SIZE_64K:  m = 21'h00ffff;
            SIZE_128K: m = 21'h01ffff;
            SIZE_512K: m = 21'h07ffff;
            SIZE_2M:   m = 21'h1fffff;
            default:   m = 21'h00ffff;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/prad_probe.sv
// One window test: aligns the base, strips mirror bits and checks the window.
`timescale 1ns / 1ps
`default_nettype none

module prad_probe (
    input  wire logic [prad_pkg::ADDR_W-1:0]  addr,
    input  wire logic [prad_pkg::SETUP_W-1:0] setup,
    input  wire prad_pkg::probe_t             probe,
    output prad_pkg::probe_res_t              res
);

    logic [prad_pkg::OFFSET_W-1:0] mask21;
    logic [prad_pkg::ADDR_W-1:0]   mask24;
    logic [prad_pkg::ADDR_W-1:0]   base;
    logic [prad_pkg::ADDR_W-1:0]   masked_addr;
    logic [prad_pkg::ADDR_W:0]     start;
    logic [prad_pkg::ADDR_W:0]     diff;
    logic [prad_pkg::OFFSET_W-1:0] span;

    always_comb begin
        mask21      = prad_pkg::sel_window_mask(setup[9:8]);
        mask24      = {3'b000, mask21};
        base        = {setup[7:0], 16'h0000} & ~mask24;
        masked_addr = addr & ~(probe.mirror & mask24);
        start       = {1'b0, base} + {1'b0, probe.start_off & mask24};
        // Clip the window to the size mask.
        span        = (probe.length_m1 > mask21) ? mask21 : probe.length_m1;
        // Sign bit set means the address sits below the start.
        diff        = {1'b0, masked_addr} - start;
        res.hit     = !diff[prad_pkg::ADDR_W] &&
                      (diff[prad_pkg::ADDR_W-1:0] <= {3'b000, span});
        res.offset  = diff[prad_pkg::OFFSET_W-1:0];
    end

endmodule

`default_nettype wire

>>> design/programmable_region_address_decoder_top.sv
// Top level of the programmable region address decoder.
//
// Usage:
//   Requests enter on s_valid/s_ready with a 24-bit s_address. Each request
//   gives exactly one result on m_valid/m_ready: hit kind, region index,
//   backing address and offset from the region start.
//   Eight setup registers (base byte in bits 7:0, size select in bits 9:8)
//   are written through cfg_write/cfg_index/cfg_data with no wait; write
//   them only while no request is in flight.
// Timing:
//   Two register stages: input register, then result register. m_valid rises
//   when the request moves on into the result register; one request per cycle
//   sustained while m_ready stays high. All nine window tests run in parallel
//   between the stages, followed by a priority pick and the backing-address add.
// Reset:
//   aresetn (synchronous, active low) clears both stage valids and all
//   setup registers to zero.
// Stall:
//   While m_ready is low the result holds; the input stage keeps accepting
//   until it also holds a request, then s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module programmable_region_address_decoder_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             cfg_write,
    input  wire logic [prad_pkg::REGION_W-1:0]    cfg_index,
    input  wire logic [prad_pkg::SETUP_W-1:0]     cfg_data,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [prad_pkg::ADDR_W-1:0]      s_address,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [prad_pkg::KIND_W-1:0]           m_hit_kind,
    output logic [prad_pkg::REGION_W-1:0]         m_region_index,
    output logic [prad_pkg::ADDR_W-1:0]           m_backing_address,
    output logic [prad_pkg::OFFSET_W-1:0]         m_region_offset
);

    logic [prad_pkg::SETUP_W-1:0]  setup_reg [prad_pkg::REGION_CNT];

    logic                          in_valid_reg;
    logic [prad_pkg::ADDR_W-1:0]   in_addr_reg;

    logic                          out_valid_reg;
    logic [prad_pkg::KIND_W-1:0]   kind_reg;
    logic [prad_pkg::REGION_W-1:0] region_reg;
    logic [prad_pkg::ADDR_W-1:0]   backing_reg;
    logic [prad_pkg::OFFSET_W-1:0] offset_reg;

    logic [prad_pkg::KIND_W-1:0]   kind_next;
    logic [prad_pkg::REGION_W-1:0] region_next;
    logic [prad_pkg::ADDR_W-1:0]   backing_next;
    logic [prad_pkg::OFFSET_W-1:0] offset_next;
    logic [prad_pkg::ADDR_W-1:0]   base_sel;

    logic                          advance_out;
    logic                          accept_in;

    prad_pkg::probe_res_t          probe_res [prad_pkg::PROBE_COUNT];

    // Setup registers: write at once, ignore nothing (index covers all eight).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < prad_pkg::REGION_CNT; i++) begin
                setup_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            setup_reg[cfg_index] <= cfg_data;
        end
    end

    // Handshake: result stage moves when empty or drained; input stage
    // accepts when empty or when it hands its request forward this cycle.
    assign advance_out = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || advance_out;
    assign accept_in   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            in_addr_reg <= s_address;
        end
    end

    // Window tests, all in parallel.
    for (genvar g = 0; g < prad_pkg::PROBE_COUNT; g++) begin : g_probe
        prad_probe u_probe (
            .addr  (in_addr_reg),
            .setup (setup_reg[prad_pkg::PROBES[g].region]),
            .probe (prad_pkg::PROBES[g]),
            .res   (probe_res[g])
        );
    end

    // Priority pick: walk from the last probe so the first hit overrides.
    always_comb begin
        kind_next   = prad_pkg::KIND_NONE;
        region_next = '0;
        offset_next = '0;
        base_sel    = '0;
        for (int i = prad_pkg::PROBE_COUNT - 1; i >= 0; i--) begin
            if (probe_res[i].hit) begin
                kind_next   = prad_pkg::PROBES[i].kind;
                region_next = prad_pkg::PROBES[i].region;
                offset_next = probe_res[i].offset;
                base_sel    = prad_pkg::PROBES[i].backing_base;
            end
        end
        // Only ROM and RAM have a backing store.
        if (kind_next inside {prad_pkg::KIND_ROM, prad_pkg::KIND_RAM}) begin
            backing_next = base_sel + {3'b000, offset_next};
        end else begin
            backing_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance_out) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_out && in_valid_reg) begin
            kind_reg    <= kind_next;
            region_reg  <= region_next;
            backing_reg <= backing_next;
            offset_reg  <= offset_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_hit_kind        = kind_reg;
    assign m_region_index    = region_reg;
    assign m_backing_address = backing_reg;
    assign m_region_offset   = offset_reg;

endmodule

`default_nettype wire

>>> tb/sv/programmable_region_address_decoder_top_tb.sv
// Self-checking testbench for the programmable region address decoder top level.
`timescale 1ns / 1ps

module programmable_region_address_decoder_top_tb;

    import prad_pkg::*;

    // Random part: one register setting per phase, a fixed number of requests each.
    localparam int RAND_PHASES = 8;
    localparam int PHASE_REQS  = 244;
    localparam int PLAN_LEN    = 47;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [REGION_W-1:0] region;
        logic [ADDR_W-1:0]   backing;
        logic [OFFSET_W-1:0] offset;
    } decode_result_t;

    // STEP_KNOWN rows carry their result; STEP_PREDICT rows go through the predictor.
    typedef enum logic [1:0] {STEP_CFG, STEP_KNOWN, STEP_PREDICT} plan_op_e;

    typedef struct packed {
        plan_op_e            op;
        logic [REGION_W-1:0] index;
        logic [SETUP_W-1:0]  setup;
        logic [ADDR_W-1:0]   addr;
        decode_result_t      want;
    } plan_step_t;

    // Directed part. Setups are base byte in bits 7:0 and size select in bits 9:8.
    localparam plan_step_t PLAN [PLAN_LEN] = '{
        // Out of reset every region sits at 0 with 64K size: region 0 owns 0..ffff.
        '{STEP_KNOWN,   3'd0, 10'h000, 24'h000000, '{KIND_ROM, 3'd0, 24'h000000, 21'h000000}},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'h00ffff, '{KIND_ROM, 3'd0, 24'h00ffff, 21'h00ffff}},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'h010000, '{KIND_NONE, 3'd0, 24'h000000, 21'h000000}},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'hffffff, '{KIND_NONE, 3'd0, 24'h000000, 21'h000000}},
        // Spread the regions out, every size select in use.
        '{STEP_CFG,     3'd0, 10'h300, 24'h000000, '0},
        '{STEP_CFG,     3'd1, 10'h220, 24'h000000, '0},
        '{STEP_CFG,     3'd2, 10'h130, 24'h000000, '0},
        '{STEP_CFG,     3'd3, 10'h0ff, 24'h000000, '0},
        '{STEP_CFG,     3'd4, 10'h144, 24'h000000, '0},
        '{STEP_CFG,     3'd5, 10'h041, 24'h000000, '0},
        '{STEP_CFG,     3'd6, 10'h284, 24'h000000, '0},
        '{STEP_CFG,     3'd7, 10'h3c0, 24'h000000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h1c0005, '0},  // region 0 mirror
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h000000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h27ffff, '0},  // region 1 mirror, last byte
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h30ffff, '0},  // tile bank
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h310000, '0},  // tile bank mirror
        '{STEP_PREDICT, 3'd0, 10'h000, 24'hff3fff, '0},  // work RAM
        '{STEP_PREDICT, 3'd0, 10'h000, 24'hffc123, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h4407ff, '0},  // sprite RAM
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h410000, '0},  // sub-window pulled to base
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h411000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h800fff, '0},  // base aligned down
        '{STEP_PREDICT, 3'd0, 10'h000, 24'hdfffff, '0},  // I/O, no backing
        // Overlap: regions 0..3 share one base and regions 4..7 another, so priority decides.
        '{STEP_CFG,     3'd0, 10'h0f0, 24'h000000, '0},
        '{STEP_CFG,     3'd1, 10'h0f0, 24'h000000, '0},
        '{STEP_CFG,     3'd2, 10'h0f0, 24'h000000, '0},
        '{STEP_CFG,     3'd3, 10'h0f0, 24'h000000, '0},
        '{STEP_CFG,     3'd4, 10'h040, 24'h000000, '0},
        '{STEP_CFG,     3'd5, 10'h040, 24'h000000, '0},
        '{STEP_CFG,     3'd6, 10'h040, 24'h000000, '0},
        '{STEP_CFG,     3'd7, 10'h040, 24'h000000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h400000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h400900, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'h40f000, '0},
        '{STEP_PREDICT, 3'd0, 10'h000, 24'hf03fff, '0},
        // All ones: 2M at e00000, region 0 mirrors over the whole window.
        '{STEP_CFG,     3'd0, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd1, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd2, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd3, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd4, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd5, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd6, 10'h3ff, 24'h000000, '0},
        '{STEP_CFG,     3'd7, 10'h3ff, 24'h000000, '0},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'he00000, '{KIND_ROM, 3'd0, 24'h000000, 21'h000000}},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'hffffff, '{KIND_ROM, 3'd0, 24'h03ffff, 21'h03ffff}},
        '{STEP_KNOWN,   3'd0, 10'h000, 24'hdfffff, '{KIND_NONE, 3'd0, 24'h000000, 21'h000000}}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_write;
    logic [REGION_W-1:0]   cfg_index;
    logic [SETUP_W-1:0]    cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_W-1:0]     m_hit_kind;
    logic [REGION_W-1:0]   m_region_index;
    logic [ADDR_W-1:0]     m_backing_address;
    logic [OFFSET_W-1:0]   m_region_offset;

    // Shadow of the setup registers, updated as each write lands.
    logic [SETUP_W-1:0]    region_setup [REGION_CNT];
    decode_result_t        expected_decodes [$];
    decode_result_t        oldest;

    bit idle_on;
    int mismatches;
    int requests_taken;
    int results_taken;
    int settings_used;
    int kinds_seen [8];
    int stall_seen;
    int stall_left;

    programmable_region_address_decoder_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit_kind        (m_hit_kind),
        .m_region_index    (m_region_index),
        .m_backing_address (m_backing_address),
        .m_region_offset   (m_region_offset)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("programmable_region_address_decoder_top verification failed");
        $finish;
    end

    function automatic int unsigned window_mask(input logic [1:0] sel);
        int unsigned m;
        case (sel)
            SIZE_64K:  m = 32'h00ffff;
            SIZE_128K: m = 32'h01ffff;
            SIZE_512K: m = 32'h07ffff;
            SIZE_2M:   m = 32'h1fffff;
            default:   m = 32'h00ffff;
        endcase
        return m;
    endfunction

    // Walk the nine window probes in priority order; the first hit decides.
    function automatic decode_result_t predict_decode(input logic [ADDR_W-1:0] addr);
        decode_result_t      res;
        logic [REGION_W-1:0] region;
        logic [KIND_W-1:0]   kind;
        logic [SETUP_W-1:0]  setup;
        int unsigned         len, mirror, start_off, backing;
        int unsigned         mask, base, start, span, last, ma;
        res = '0;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin region = 3'd0; kind = KIND_ROM;  len = 'h40000; mirror = 'hfc0000;
                         start_off = 0; backing = 'h000000; end
                1: begin region = 3'd1; kind = KIND_ROM;  len = 'h40000; mirror = 'hfc0000;
                         start_off = 0; backing = 'h040000; end
                2: begin region = 3'd2; kind = KIND_TILE; len = 'h10000; mirror = 'hff0000;
                         start_off = 0; backing = 0; end
                3: begin region = 3'd3; kind = KIND_RAM;  len = 'h04000; mirror = 'hffc000;
                         start_off = 0; backing = 'hffc000; end
                4: begin region = 3'd4; kind = KIND_RAM;  len = 'h00800; mirror = 'hfff800;
                         start_off = 0; backing = 'h440000; end
                5: begin region = 3'd5; kind = KIND_RAM;  len = 'h01000; mirror = 'hfef000;
                         start_off = 'h10000; backing = 'h410000; end
                6: begin region = 3'd5; kind = KIND_RAM;  len = 'h10000; mirror = 'hfe0000;
                         start_off = 0; backing = 'h400000; end
                7: begin region = 3'd6; kind = KIND_RAM;  len = 'h01000; mirror = 'hfff000;
                         start_off = 0; backing = 'h840000; end
                default: begin region = 3'd7; kind = KIND_IO; len = 'h04000; mirror = 'hffc000;
                         start_off = 0; backing = 0; end
            endcase
            setup = region_setup[region];
            mask  = window_mask(setup[9:8]);
            base  = {8'h00, setup[7:0], 16'h0000} & ~mask;
            start = base + (start_off & mask);
            span  = len - 1;
            if (span > mask)
                span = mask;
            last  = start + span;
            ma    = {8'h00, addr} & ~(mirror & mask);
            if (ma >= start && ma <= last) begin
                res.kind   = kind;
                res.region = region;
                if (kind == KIND_ROM || kind == KIND_RAM)
                    res.backing = ADDR_W'(backing + ma - start);
                res.offset = OFFSET_W'(ma - start);
                return res;
            end
        end
        return res;
    endfunction

    // Mostly land inside some region's window so the probes get exercised;
    // clearing bits 15:12 now and then favors the small sub-windows.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [SETUP_W-1:0] setup;
        int unsigned        mask, low;
        if ($urandom_range(0, 3) == 0)
            return ADDR_W'($urandom);
        setup = region_setup[$urandom_range(0, REGION_CNT - 1)];
        mask  = window_mask(setup[9:8]);
        low   = $urandom & mask;
        if ($urandom_range(0, 1) == 1)
            low = low & 32'h1f0fff;
        return ADDR_W'(({8'h00, setup[7:0], 16'h0000} & ~mask) | low);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Offer one request, after a random gap while idling is on, hold it until taken, then log what it owes.
    task automatic send_request(input logic [ADDR_W-1:0] addr, input bit known,
                                input decode_result_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_decodes.push_back(known ? want : predict_decode(addr));
        requests_taken++;
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_setup(input logic [REGION_W-1:0] idx, input logic [SETUP_W-1:0] val);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_write <= 1'b0;
        region_setup[idx] = val;
    endtask

    // Result side: after each taken result, hold m_ready low for a random stall while idling is on.
    always @(negedge aclk) begin
        if (results_taken != stall_seen) begin
            stall_seen = results_taken;
            stall_left = idle_on ? $urandom_range(0, 7) : 0;
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each taken result field by field against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (expected_decodes.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d region %0d",
                                          m_hit_kind, m_region_index));
            end else begin
                oldest = expected_decodes.pop_front();
                kinds_seen[m_hit_kind]++;
                if (m_hit_kind !== oldest.kind)
                    report_mismatch($sformatf("hit_kind %0d, want %0d",
                                              m_hit_kind, oldest.kind));
                if (m_region_index !== oldest.region)
                    report_mismatch($sformatf("region_index %0d, want %0d",
                                              m_region_index, oldest.region));
                if (m_backing_address !== oldest.backing)
                    report_mismatch($sformatf("backing_address %06h, want %06h",
                                              m_backing_address, oldest.backing));
                if (m_region_offset !== oldest.offset)
                    report_mismatch($sformatf("region_offset %06h, want %06h",
                                              m_region_offset, oldest.offset));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_address = '0;
        m_ready   = 1'b0;
        idle_on   = 1'b1;
        for (int r = 0; r < REGION_CNT; r++)
            region_setup[r] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: register writes wait for the pipe to empty first.
        for (int i = 0; i < PLAN_LEN; i++) begin
            case (PLAN[i].op)
                STEP_CFG: begin
                    wait_drain();
                    write_setup(PLAN[i].index, PLAN[i].setup);
                end
                STEP_KNOWN:   send_request(PLAN[i].addr, 1'b1, PLAN[i].want);
                STEP_PREDICT: send_request(PLAN[i].addr, 1'b0, '0);
                default: ;
            endcase
        end
        settings_used = 4;

        // Random phases: all-zero setups first, a mix of extremes last,
        // random setups between; every third phase runs without idling.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drain();
            idle_on = (phase % 3 != 1);
            for (int r = 0; r < REGION_CNT; r++) begin
                if (phase == 0)
                    write_setup(REGION_W'(r), '0);
                else if (phase == RAND_PHASES - 1)
                    write_setup(REGION_W'(r), $urandom_range(0, 1) ? 10'h3ff : 10'h000);
                else
                    write_setup(REGION_W'(r), SETUP_W'($urandom));
            end
            settings_used++;
            for (int n = 0; n < PHASE_REQS; n++) begin
                // Now and then let the pipe run dry mid-phase.
                if ($urandom_range(0, 199) == 0)
                    wait_drain();
                send_request(random_address(), 1'b0, '0);
            end
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        if (expected_decodes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_decodes.size()));

        $display("Decoded %0d requests over %0d register settings, with and without idling.",
                 requests_taken, settings_used);
        $display("Results by kind: none %0d, ROM %0d, RAM %0d, I/O %0d, tile bank %0d.",
                 kinds_seen[KIND_NONE], kinds_seen[KIND_ROM], kinds_seen[KIND_RAM],
                 kinds_seen[KIND_IO], kinds_seen[KIND_TILE]);
        if (mismatches == 0) begin
            $display("programmable_region_address_decoder_top verification clean");
        end else begin
            $display("programmable_region_address_decoder_top verification failed");
        end
        $finish;
    end

endmodule
